// ===== hdl/imts_pkg.sv =====
// shared types, constants and helpers of the inline markup tag scanner
package imts_pkg;

  localparam int unsigned POS_BITS       = 32;
  localparam int unsigned MARK_BITS      = 32;
  localparam int unsigned WIDE_BITS      = (POS_BITS > MARK_BITS) ? POS_BITS : MARK_BITS;
  localparam int unsigned FAMILIES       = 3;
  localparam int unsigned FAM_BITS       = 2;
  localparam int unsigned KIND_BITS      = 3;
  localparam int unsigned TAG_NAME_CHARS = 6;
  localparam int unsigned CNT_BITS       = 3;
  localparam int unsigned ALIASES        = 6;
  localparam int unsigned EVQ_DEPTH      = 4;
  localparam int unsigned EVQ_PTR_BITS   = 2;

  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_GT    = 8'h3E;

  // tag names, lower case, two per family: b strong / i em / s del
  localparam logic [7:0] ALIAS_TEXT [ALIASES][TAG_NAME_CHARS] = '{
    '{8'h62, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h74, 8'h72, 8'h6F, 8'h6E, 8'h67},
    '{8'h69, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h65, 8'h6D, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h73, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h65, 8'h6C, 8'h00, 8'h00, 8'h00}
  };
  localparam logic [CNT_BITS-1:0] ALIAS_LEN [ALIASES] = '{
    3'd1, 3'd6, 3'd1, 3'd2, 3'd1, 3'd3
  };

  localparam logic [KIND_BITS-1:0] KIND_BOLD_START   = 3'd0;
  localparam logic [KIND_BITS-1:0] KIND_BOLD_END     = 3'd1;
  localparam logic [KIND_BITS-1:0] KIND_ITALIC_START = 3'd2;
  localparam logic [KIND_BITS-1:0] KIND_ITALIC_END   = 3'd3;
  localparam logic [KIND_BITS-1:0] KIND_STRIKE_START = 3'd4;
  localparam logic [KIND_BITS-1:0] KIND_STRIKE_END   = 3'd5;

  localparam logic [FAM_BITS-1:0] FAM_BOLD   = 2'd0;
  localparam logic [FAM_BITS-1:0] FAM_ITALIC = 2'd1;
  localparam logic [FAM_BITS-1:0] FAM_STRIKE = 2'd2;

  typedef logic [POS_BITS-1:0] pos_t;

  // one resolved '>' with the families that produce a marker
  typedef struct packed {
    logic [FAMILIES-1:0] fire;
    logic [FAMILIES-1:0] closing;
    pos_t [FAMILIES-1:0] tag_pos;
    pos_t                gt_pos;
  } imts_event_t;

  function automatic logic [KIND_BITS-1:0] fam_kind(input logic [FAM_BITS-1:0] fam,
                                                    input logic closing);
    logic [KIND_BITS-1:0] kind;
    unique case (fam)
      FAM_BOLD:   kind = closing ? KIND_BOLD_END : KIND_BOLD_START;
      FAM_ITALIC: kind = closing ? KIND_ITALIC_END : KIND_ITALIC_START;
      FAM_STRIKE: kind = closing ? KIND_STRIKE_END : KIND_STRIKE_START;
      default:    kind = KIND_BOLD_START;
    endcase
    return kind;
  endfunction

endpackage

// ===== hdl/imts_front.sv =====
// front end: byte scanner, tag name match and per-family open/pending state
module imts_front import imts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        take_i,
  input  logic [7:0]  byte_i,
  input  logic        eot_i,
  output logic        ev_push_o,
  output imts_event_t ev_o
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_LT   = 2'd1;
  localparam logic [1:0] PH_NAME = 2'd2;

  pos_t                pos_q, pos_d;
  logic [1:0]          phase_q, phase_d;
  pos_t                start_q, start_d;
  logic                closing_q, closing_d;
  logic [7:0]          name_q [TAG_NAME_CHARS];
  logic [7:0]          name_d [TAG_NAME_CHARS];
  logic [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                ovf_q, ovf_d;
  logic [FAMILIES-1:0] wait_q, wait_d;
  pos_t [FAMILIES-1:0] fpos_q, fpos_d;
  logic [FAMILIES-1:0] fclose_q, fclose_d;
  logic [FAMILIES-1:0] open_q, open_d;

  logic [ALIASES-1:0]  alias_hit;
  logic [FAMILIES-1:0] fam_hit;
  logic [FAMILIES-1:0] wait_mid;
  pos_t [FAMILIES-1:0] fpos_mid;
  logic [FAMILIES-1:0] fclose_mid;
  logic [FAMILIES-1:0] fire;
  logic [7:0]          lower;
  logic                is_name, lt_slash, name_ch, other, finish, is_gt;

  always_comb begin
    for (int a = 0; a < ALIASES; a++) begin
      alias_hit[a] = (cnt_q == ALIAS_LEN[a]);
      for (int k = 0; k < TAG_NAME_CHARS; k++) begin
        if ((k < int'(ALIAS_LEN[a])) && (name_q[k] != ALIAS_TEXT[a][k])) begin
          alias_hit[a] = 1'b0;
        end
      end
    end
    for (int f = 0; f < FAMILIES; f++) begin
      fam_hit[f] = !ovf_q && (cnt_q != '0) && (alias_hit[2*f] || alias_hit[2*f+1]);
    end
  end

  assign is_name = ((byte_i >= 8'h61) && (byte_i <= 8'h7A)) ||
                   ((byte_i >= 8'h41) && (byte_i <= 8'h5A)) ||
                   ((byte_i >= 8'h30) && (byte_i <= 8'h39));
  assign lower    = ((byte_i >= 8'h41) && (byte_i <= 8'h5A)) ? byte_i + 8'h20 : byte_i;
  assign lt_slash = (phase_q == PH_LT) && (byte_i == CH_SLASH);
  assign name_ch  = !lt_slash && (phase_q != PH_IDLE) && is_name;
  assign other    = !lt_slash && !name_ch;
  assign finish   = other && (phase_q != PH_IDLE);
  assign is_gt    = other && (byte_i == CH_GT);

  // first tag of a family since its last '>' wins
  always_comb begin
    for (int f = 0; f < FAMILIES; f++) begin
      wait_mid[f]   = wait_q[f];
      fpos_mid[f]   = fpos_q[f];
      fclose_mid[f] = fclose_q[f];
      if (finish && fam_hit[f] && !wait_q[f]) begin
        wait_mid[f]   = 1'b1;
        fpos_mid[f]   = start_q;
        fclose_mid[f] = closing_q;
      end
      // open while closed, or close while open
      fire[f] = wait_mid[f] && (fclose_mid[f] == open_q[f]);
    end
  end

  assign ev_push_o     = take_i && is_gt && (fire != '0);
  assign ev_o.fire     = fire;
  assign ev_o.closing  = fclose_mid;
  assign ev_o.tag_pos  = fpos_mid;
  assign ev_o.gt_pos   = pos_q;

  always_comb begin
    pos_d     = pos_q;
    phase_d   = phase_q;
    start_d   = start_q;
    closing_d = closing_q;
    name_d    = name_q;
    cnt_d     = cnt_q;
    ovf_d     = ovf_q;
    wait_d    = wait_q;
    fpos_d    = fpos_q;
    fclose_d  = fclose_q;
    open_d    = open_q;
    if (take_i) begin
      wait_d   = wait_mid;
      fpos_d   = fpos_mid;
      fclose_d = fclose_mid;
      if (lt_slash) begin
        closing_d = 1'b1;
        phase_d   = PH_NAME;
      end else if (name_ch) begin
        phase_d = PH_NAME;
        if (cnt_q < CNT_BITS'(TAG_NAME_CHARS)) begin
          for (int k = 0; k < TAG_NAME_CHARS; k++) begin
            if (cnt_q == CNT_BITS'(k)) begin
              name_d[k] = lower;
            end
          end
          cnt_d = cnt_q + 1'b1;
        end else begin
          ovf_d = 1'b1;
        end
      end else begin
        phase_d = PH_IDLE;
        if (byte_i == CH_LT) begin
          phase_d   = PH_LT;
          start_d   = pos_q;
          closing_d = 1'b0;
          cnt_d     = '0;
          ovf_d     = 1'b0;
        end else if (byte_i == CH_GT) begin
          wait_d = '0;
          open_d = open_q ^ fire;
        end
      end
      // position saturates at all ones
      if (pos_q != '1) begin
        pos_d = pos_q + 1'b1;
      end
      if (eot_i) begin
        pos_d     = '0;
        phase_d   = PH_IDLE;
        start_d   = '0;
        closing_d = 1'b0;
        for (int k = 0; k < TAG_NAME_CHARS; k++) begin
          name_d[k] = '0;
        end
        cnt_d  = '0;
        ovf_d  = 1'b0;
        wait_d = '0;
        open_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      phase_q   <= PH_IDLE;
      start_q   <= '0;
      closing_q <= 1'b0;
      for (int k = 0; k < TAG_NAME_CHARS; k++) begin
        name_q[k] <= '0;
      end
      cnt_q  <= '0;
      ovf_q  <= 1'b0;
      wait_q <= '0;
      open_q <= '0;
    end else begin
      pos_q     <= pos_d;
      phase_q   <= phase_d;
      start_q   <= start_d;
      closing_q <= closing_d;
      name_q    <= name_d;
      cnt_q     <= cnt_d;
      ovf_q     <= ovf_d;
      wait_q    <= wait_d;
      open_q    <= open_d;
    end
  end

  // pending tag payload, only read while its wait bit is set
  always_ff @(posedge clk_i) begin
    fpos_q   <= fpos_d;
    fclose_q <= fclose_d;
  end

endmodule

// ===== hdl/imts_evq.sv =====
// short event queue between the scanner front end and the marker back end
module imts_evq import imts_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  imts_event_t data_i,
  input  logic        pop_i,
  output logic        full_o,
  output logic        empty_o,
  output imts_event_t data_o
);

  imts_event_t               mem_q [EVQ_DEPTH];
  logic [EVQ_PTR_BITS-1:0]   wr_q, rd_q;
  logic [EVQ_PTR_BITS:0]     cnt_q;

  assign full_o  = (cnt_q == (EVQ_PTR_BITS+1)'(EVQ_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== hdl/imts_back.sv =====
// back end: emits the markers of one event in position order, one per cycle while popped
module imts_back import imts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 ev_empty_i,
  input  imts_event_t          ev_i,
  output logic                 ev_pop_o,
  input  logic                 pop_i,
  output logic                 empty_o,
  output logic [MARK_BITS-1:0] marker_pos_o,
  output logic [MARK_BITS-1:0] marker_length_o,
  output logic [KIND_BITS-1:0] marker_kind_o,
  output logic                 last_of_run_o
);

  logic [FAMILIES-1:0]  mask_q, mask_d, sel, mask_rest;
  imts_event_t          cur_q;
  logic                 out_valid_q;
  logic [MARK_BITS-1:0] pos_out_q, len_out_q;
  logic [KIND_BITS-1:0] kind_out_q;
  logic                 last_out_q;

  logic                 adv, can_load;
  pos_t                 sel_pos;
  logic [FAM_BITS-1:0]  sel_fam;
  logic                 sel_close;
  logic [WIDE_BITS-1:0] span;

  assign adv = (mask_q != '0) && (!out_valid_q || pop_i);

  // pick the earliest remaining tag, lower family first on a tie
  always_comb begin
    for (int f = 0; f < FAMILIES; f++) begin
      sel[f] = mask_q[f];
      for (int g = 0; g < FAMILIES; g++) begin
        if ((g != f) && mask_q[g]) begin
          if (!((cur_q.tag_pos[f] < cur_q.tag_pos[g]) ||
                ((cur_q.tag_pos[f] == cur_q.tag_pos[g]) && (f < g)))) begin
            sel[f] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    sel_pos   = '0;
    sel_fam   = '0;
    sel_close = 1'b0;
    for (int f = 0; f < FAMILIES; f++) begin
      if (sel[f]) begin
        sel_pos   = cur_q.tag_pos[f];
        sel_fam   = FAM_BITS'(f);
        sel_close = cur_q.closing[f];
      end
    end
  end

  assign span      = WIDE_BITS'(cur_q.gt_pos) - WIDE_BITS'(sel_pos) + 1'b1;
  assign mask_rest = mask_q & ~sel;
  assign can_load  = (mask_q == '0) || (adv && (mask_rest == '0));
  assign ev_pop_o  = can_load && !ev_empty_i;

  always_comb begin
    mask_d = mask_q;
    if (ev_pop_o) begin
      mask_d = ev_i.fire;
    end else if (adv) begin
      mask_d = mask_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_pop_o) begin
      cur_q <= ev_i;
    end
    if (adv) begin
      pos_out_q  <= MARK_BITS'(WIDE_BITS'(sel_pos));
      len_out_q  <= span[MARK_BITS-1:0];
      kind_out_q <= fam_kind(sel_fam, sel_close);
      last_out_q <= (mask_rest == '0);
    end
  end

  assign empty_o         = !out_valid_q;
  assign marker_pos_o    = pos_out_q;
  assign marker_length_o = len_out_q;
  assign marker_kind_o   = kind_out_q;
  assign last_of_run_o   = last_out_q;

endmodule

// ===== hdl/inline_markup_tag_scanner_core.sv =====
// Inline markup tag scanner: finds bold, italic and strike HTML tags in a byte stream.
//
// Input channel: one text byte per transfer (push while full is low), with
// end_of_text_i on the last byte of a document; after that byte all scanner
// state, open flags included, returns to its reset value.
// Result channel: a marker (position of '<', length through '>', kind, and
// last_of_run on the final marker of one '>') sits on the ports while empty
// is low and leaves on pop.
// Throughput: one byte per cycle while full is low; the back end emits one marker
// per cycle while popped, so a '>' resolving three families yields three markers.
// Path: a marker's '>' event is written to the event queue, loaded into the back end's
// current event register and then into its output register when nothing is ahead.
// A four-entry event queue sits between scanner and marker sequencer. Bytes
// keep flowing while the receiver stalls until that queue fills; full then
// rises and holds the input until markers are popped.
// Reset: asynchronous, active low; empties the queue and output, positions at
// zero, all families closed.
module inline_markup_tag_scanner_core import imts_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           text_byte_i,
  input  logic                 end_of_text_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [MARK_BITS-1:0] marker_pos_o,
  output logic [MARK_BITS-1:0] marker_length_o,
  output logic [KIND_BITS-1:0] marker_kind_o,
  output logic                 last_of_run_o
);

  logic        take;
  logic        ev_push, ev_pop, ev_empty;
  imts_event_t ev_in, ev_out;

  assign take = push && !full;

  imts_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .byte_i    (text_byte_i),
    .eot_i     (end_of_text_i),
    .ev_push_o (ev_push),
    .ev_o      (ev_in)
  );

  imts_evq u_evq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (ev_push),
    .data_i  (ev_in),
    .pop_i   (ev_pop),
    .full_o  (full),
    .empty_o (ev_empty),
    .data_o  (ev_out)
  );

  imts_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ev_empty_i      (ev_empty),
    .ev_i            (ev_out),
    .ev_pop_o        (ev_pop),
    .pop_i           (pop && !empty),
    .empty_o         (empty),
    .marker_pos_o    (marker_pos_o),
    .marker_length_o (marker_length_o),
    .marker_kind_o   (marker_kind_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

// ===== hdl/imts_checker.sv =====
// port-level checks of the tag scanner, bound to the top level
module imts_checker import imts_pkg::*; (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 full,
  input logic                 empty,
  input logic                 pop,
  input logic [MARK_BITS-1:0] marker_pos_o,
  input logic [MARK_BITS-1:0] marker_length_o,
  input logic [KIND_BITS-1:0] marker_kind_o,
  input logic                 last_of_run_o
);

  // nothing on offer and room for input once reset has taken hold
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |=> (empty && !full))
    else $error("outputs not quiet in reset");

  // a waiting marker holds until its transfer
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(marker_pos_o) &&
      $stable(marker_length_o) && $stable(marker_kind_o) && $stable(last_of_run_o)))
    else $error("waiting marker changed");

  // markers of one '>' leave back to back
  a_run_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !last_of_run_o) |=> !empty)
    else $error("gap inside a marker run");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (marker_kind_o <= KIND_STRIKE_END))
    else $error("marker kind out of range");

endmodule

bind inline_markup_tag_scanner_core imts_checker u_imts_checker (.*);
